// File: design/mipsx_pkg.sv
// Shared types and codes for the MIPS integer execute block.
// No dependencies.
package mipsx_pkg;

  localparam int unsigned NumRegs  = 32;
  localparam int unsigned RegIdxW  = 5;
  localparam int unsigned DataW    = 32;

  // item kinds
  localparam logic [1:0] KIND_EXEC  = 2'd0;
  localparam logic [1:0] KIND_READ  = 2'd1;
  localparam logic [1:0] KIND_CLEAR = 2'd2;

  // R-type funct codes
  localparam logic [5:0] FN_SLL  = 6'd0;
  localparam logic [5:0] FN_SRL  = 6'd2;
  localparam logic [5:0] FN_SRA  = 6'd3;
  localparam logic [5:0] FN_SLLV = 6'd4;
  localparam logic [5:0] FN_SRLV = 6'd6;
  localparam logic [5:0] FN_SRAV = 6'd7;
  localparam logic [5:0] FN_ADD  = 6'd32;
  localparam logic [5:0] FN_ADDU = 6'd33;
  localparam logic [5:0] FN_SUB  = 6'd34;
  localparam logic [5:0] FN_SUBU = 6'd35;
  localparam logic [5:0] FN_AND  = 6'd36;
  localparam logic [5:0] FN_OR   = 6'd37;
  localparam logic [5:0] FN_XOR  = 6'd38;
  localparam logic [5:0] FN_NOR  = 6'd39;
  localparam logic [5:0] FN_SLT  = 6'd42;
  localparam logic [5:0] FN_SLTU = 6'd43;

  // opcodes
  localparam logic [5:0] OP_RTYPE = 6'd0;
  localparam logic [5:0] OP_ADDI  = 6'd8;
  localparam logic [5:0] OP_ADDIU = 6'd9;
  localparam logic [5:0] OP_SLTI  = 6'd10;
  localparam logic [5:0] OP_SLTIU = 6'd11;
  localparam logic [5:0] OP_ANDI  = 6'd12;
  localparam logic [5:0] OP_ORI   = 6'd13;
  localparam logic [5:0] OP_XORI  = 6'd14;
  localparam logic [5:0] OP_LUI   = 6'd15;

  typedef struct packed {
    logic [1:0]         kind;
    logic [DataW-1:0]   instruction;
    logic [RegIdxW-1:0] read_index;
  } req_t;

  typedef struct packed {
    logic [RegIdxW-1:0] dest_index;
    logic [DataW-1:0]   value;
    logic               wrote;
    logic               unknown;
  } rsp_t;

endpackage

// File: design/mipsx_alu.sv
// Instruction decode and ALU for one execute word.
// Depends on mipsx_pkg.
module mipsx_alu (
  input  logic [1:0]                      kind,
  input  logic [mipsx_pkg::DataW-1:0]     instruction,
  input  logic [mipsx_pkg::RegIdxW-1:0]   read_index,
  input  logic [mipsx_pkg::DataW-1:0]     a,
  input  logic [mipsx_pkg::DataW-1:0]     b,
  output mipsx_pkg::rsp_t                 res
);
  import mipsx_pkg::*;

  logic [5:0]         opcode;
  logic [5:0]         funct;
  logic [4:0]         rt;
  logic [4:0]         rd;
  logic [4:0]         shamt;
  logic [15:0]        imm;
  logic [DataW-1:0]   imm_s;
  logic [DataW-1:0]   imm_z;
  logic [DataW-1:0]   r;
  logic [RegIdxW-1:0] dest;
  logic               ok;

  assign opcode = instruction[31:26];
  assign rt     = instruction[20:16];
  assign rd     = instruction[15:11];
  assign shamt  = instruction[10:6];
  assign funct  = instruction[5:0];
  assign imm    = instruction[15:0];
  assign imm_s  = {{16{imm[15]}}, imm};
  assign imm_z  = {16'b0, imm};

  always_comb begin
    r    = '0;
    ok   = 1'b1;
    dest = rd;
    if (opcode == OP_RTYPE) begin
      dest = rd;
      unique case (funct) inside
        FN_SLL:          r = b << shamt;
        FN_SRL:          r = b >> shamt;
        FN_SRA:          r = DataW'($signed(b) >>> shamt);
        FN_SLLV:         r = b << a[4:0];
        FN_SRLV:         r = b >> a[4:0];
        FN_SRAV:         r = DataW'($signed(b) >>> a[4:0]);
        FN_ADD, FN_ADDU: r = a + b;
        FN_SUB, FN_SUBU: r = a - b;
        FN_AND:          r = a & b;
        FN_OR:           r = a | b;
        FN_XOR:          r = a ^ b;
        FN_NOR:          r = ~(a | b);
        FN_SLT:          r = {31'b0, $signed(a) < $signed(b)};
        FN_SLTU:         r = {31'b0, a < b};
        default:         ok = 1'b0;
      endcase
    end else begin
      dest = rt;
      unique case (opcode) inside
        OP_ADDI, OP_ADDIU: r = a + imm_s;
        OP_SLTI:           r = {31'b0, $signed(a) < $signed(imm_s)};
        OP_SLTIU:          r = {31'b0, a < imm_s};
        OP_ANDI:           r = a & imm_z;
        OP_ORI:            r = a | imm_z;
        OP_XORI:           r = a ^ imm_z;
        OP_LUI:            r = {imm, 16'b0};
        default:           ok = 1'b0;
      endcase
    end
  end

  always_comb begin
    res = '0;
    unique case (kind)
      KIND_EXEC: begin
        if (!ok) begin
          res.unknown = 1'b1;
        end else if (dest != '0) begin
          res.dest_index = dest;
          res.value      = r;
          res.wrote      = 1'b1;
        end
      end
      KIND_READ: begin
        res.dest_index = read_index;
        res.value      = a;
      end
      default: res = '0;
    endcase
  end

endmodule

// File: design/mips_alu_execute_regfile.sv
// A word accepted is held in the operand stage (operand read), then in the
// result register (execute and write-back). Throughput: one word per cycle
// while rsp_stall does not hold the output; the last write-back is forwarded
// to the operands of the next word. Reset empties the pipeline and marks all
// registers zero through one valid bit each; a clear word clears those bits.
// Depends on mipsx_pkg and mipsx_alu.
module mips_alu_execute_regfile (
  input  logic            clk,
  input  logic            rst,
  input  logic            req_valid,
  output logic            req_stall,
  input  mipsx_pkg::req_t req,
  output logic            rsp_valid,
  input  logic            rsp_stall,
  output mipsx_pkg::rsp_t rsp
);
  import mipsx_pkg::*;

  logic [DataW-1:0]   mem [NumRegs];
  logic [NumRegs-1:0] reg_valid;

  // operand stage
  logic               x_valid;
  req_t               x_req;
  logic [RegIdxW-1:0] x_addr_a;
  logic [RegIdxW-1:0] x_addr_b;
  logic [DataW-1:0]   x_mem_a;
  logic [DataW-1:0]   x_mem_b;
  logic               x_vld_a;
  logic               x_vld_b;

  // last write-back
  logic               wb_en;
  logic               wb_clr;
  logic [RegIdxW-1:0] wb_idx;
  logic [DataW-1:0]   wb_val;

  logic               in_fire;
  logic               x_fire;
  logic               out_free;
  logic [RegIdxW-1:0] addr_a;
  logic [RegIdxW-1:0] addr_b;
  logic [DataW-1:0]   op_a;
  logic [DataW-1:0]   op_b;
  rsp_t               res;

  assign out_free  = !rsp_valid || !rsp_stall;
  assign x_fire    = x_valid && out_free;
  assign req_stall = x_valid && !out_free;
  assign in_fire   = req_valid && !req_stall;

  assign addr_a = (req.kind == KIND_READ) ? req.read_index : req.instruction[25:21];
  assign addr_b = req.instruction[20:16];

  always_ff @(posedge clk) begin
    if (in_fire) begin
      x_req    <= req;
      x_addr_a <= addr_a;
      x_addr_b <= addr_b;
      x_mem_a  <= mem[addr_a];
      x_mem_b  <= mem[addr_b];
      x_vld_a  <= reg_valid[addr_a];
      x_vld_b  <= reg_valid[addr_b];
    end
    if (x_fire && res.wrote) begin
      mem[res.dest_index] <= res.value;
    end
  end

  always_comb begin
    if (x_addr_a == '0 || wb_clr) begin
      op_a = '0;
    end else if (wb_en && wb_idx == x_addr_a) begin
      op_a = wb_val;
    end else begin
      op_a = x_vld_a ? x_mem_a : '0;
    end
    if (x_addr_b == '0 || wb_clr) begin
      op_b = '0;
    end else if (wb_en && wb_idx == x_addr_b) begin
      op_b = wb_val;
    end else begin
      op_b = x_vld_b ? x_mem_b : '0;
    end
  end

  mipsx_alu u_alu (
    .kind        (x_req.kind),
    .instruction (x_req.instruction),
    .read_index  (x_req.read_index),
    .a           (op_a),
    .b           (op_b),
    .res         (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      x_valid   <= 1'b0;
      rsp_valid <= 1'b0;
      reg_valid <= '0;
      wb_en     <= 1'b0;
      wb_clr    <= 1'b0;
    end else begin
      if (in_fire) begin
        x_valid <= 1'b1;
      end else if (x_fire) begin
        x_valid <= 1'b0;
      end
      if (out_free) begin
        rsp_valid <= x_valid;
      end
      if (x_fire) begin
        wb_en  <= res.wrote;
        wb_clr <= (x_req.kind == KIND_CLEAR);
        if (x_req.kind == KIND_CLEAR) begin
          reg_valid <= '0;
        end else if (res.wrote) begin
          reg_valid[res.dest_index] <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (x_fire) begin
      rsp    <= res;
      wb_idx <= res.dest_index;
      wb_val <= res.value;
    end
  end

endmodule

// File: test/mips_alu_execute_regfile_tb.sv
// Testbench for mips_alu_execute_regfile: a directed table, then random words,
// checked against fixed table results or a register-file predictor, with random stalls on both sides.
// Depends on mipsx_pkg and the design files.
`timescale 1ns / 1ps

module mips_alu_execute_regfile_tb;
  import mipsx_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 200_000;
  localparam logic [1:0] KIND_NONE = 2'd3;
  localparam logic [5:0] OP_REGIMM = 6'd1;
  localparam logic [5:0] OP_LW     = 6'd35;
  localparam logic [5:0] FN_MULT   = 6'd24;

  typedef struct {
    req_t w;
    bit   fixed;
    rsp_t want;
  } dir_row_t;

  logic clk;
  logic rst       = 1'b1;
  logic req_valid = 1'b0;
  logic req_stall;
  req_t req       = '0;
  logic rsp_valid;
  logic rsp_stall = 1'b0;
  rsp_t rsp;

  logic [31:0] gpr [32];
  rsp_t        pending_rsp [$];
  dir_row_t    dir_tab [$];
  rsp_t        chk_want;
  int unsigned mismatch_cnt = 0;
  int unsigned cycle_cnt = 0;
  bit          calm = 1'b0;

  mips_alu_execute_regfile u_dut (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  function automatic rsp_t exec_predict(input req_t w);
    logic [5:0]  opc, fn;
    logic [4:0]  rs, rt, rd, sh, dst;
    logic [31:0] a, b, imm_z, imm_s, r;
    bit          ok;
    rsp_t        o;
    o     = '0;
    opc   = w.instruction[31:26];
    rs    = w.instruction[25:21];
    rt    = w.instruction[20:16];
    rd    = w.instruction[15:11];
    sh    = w.instruction[10:6];
    fn    = w.instruction[5:0];
    imm_z = {16'd0, w.instruction[15:0]};
    imm_s = {{16{w.instruction[15]}}, w.instruction[15:0]};
    ok    = 1'b1;
    r     = '0;
    case (w.kind)
      KIND_EXEC: begin
        a = gpr[rs];
        b = gpr[rt];
        if (opc == OP_RTYPE) begin
          dst = rd;
          case (fn)
            FN_SLL:  r = b << sh;
            FN_SRL:  r = b >> sh;
            FN_SRA:  r = $unsigned($signed(b) >>> sh);
            FN_SLLV: r = b << a[4:0];
            FN_SRLV: r = b >> a[4:0];
            FN_SRAV: r = $unsigned($signed(b) >>> a[4:0]);
            FN_ADD, FN_ADDU: r = a + b;
            FN_SUB, FN_SUBU: r = a - b;
            FN_AND:  r = a & b;
            FN_OR:   r = a | b;
            FN_XOR:  r = a ^ b;
            FN_NOR:  r = ~(a | b);
            FN_SLT:  r = {31'd0, $signed(a) < $signed(b)};
            FN_SLTU: r = {31'd0, a < b};
            default: ok = 1'b0;
          endcase
        end else begin
          dst = rt;
          case (opc)
            OP_ADDI, OP_ADDIU: r = a + imm_s;
            OP_SLTI:  r = {31'd0, $signed(a) < $signed(imm_s)};
            OP_SLTIU: r = {31'd0, a < imm_s};
            OP_ANDI:  r = a & imm_z;
            OP_ORI:   r = a | imm_z;
            OP_XORI:  r = a ^ imm_z;
            OP_LUI:   r = {w.instruction[15:0], 16'd0};
            default:  ok = 1'b0;
          endcase
        end
        if (!ok) begin
          o.unknown = 1'b1;
        end else if (dst != 5'd0) begin
          gpr[dst]     = r;
          o.dest_index = dst;
          o.value      = r;
          o.wrote      = 1'b1;
        end
      end
      KIND_READ: begin
        o.dest_index = w.read_index;
        o.value      = gpr[w.read_index];
      end
      KIND_CLEAR: begin
        foreach (gpr[i]) gpr[i] = '0;
      end
      default: ;
    endcase
    return o;
  endfunction

  function automatic req_t word(input logic [1:0] k, input logic [31:0] insn,
                                input logic [4:0] idx);
    req_t w;
    w.kind        = k;
    w.instruction = insn;
    w.read_index  = idx;
    return w;
  endfunction

  function automatic req_t rw(input logic [5:0] fn, input logic [4:0] rd, rs, rt, sh);
    return word(KIND_EXEC, {OP_RTYPE, rs, rt, rd, sh, fn}, 5'd0);
  endfunction

  function automatic req_t iw(input logic [5:0] op, input logic [4:0] rt, rs,
                              input logic [15:0] imm);
    return word(KIND_EXEC, {op, rs, rt, imm}, 5'd0);
  endfunction

  function automatic rsp_t res(input logic [4:0] dst, input logic [31:0] val,
                               input logic wr, unk);
    rsp_t o;
    o.dest_index = dst;
    o.value      = val;
    o.wrote      = wr;
    o.unknown    = unk;
    return o;
  endfunction

  task automatic add_row(input req_t w, input bit fixed, input rsp_t want);
    dir_row_t row;
    row.w     = w;
    row.fixed = fixed;
    row.want  = want;
    dir_tab.push_back(row);
  endtask

  // dense picks from a few registers build dependency chains
  function automatic logic [4:0] pick_reg();
    if ($urandom_range(1) == 0) return 5'($urandom_range(3));
    return 5'($urandom_range(31));
  endfunction

  function automatic req_t rand_word();
    req_t        w;
    int unsigned pick;
    logic [5:0]  fn, op;
    logic [4:0]  rs, rt, rd;
    w    = word(KIND_EXEC, $urandom(), 5'($urandom_range(31)));
    pick = $urandom_range(99);
    rs   = pick_reg();
    rt   = pick_reg();
    rd   = pick_reg();
    fn   = FN_SLL;
    op   = OP_ADDI;
    if (pick < 58) begin
      case ($urandom_range(15))
        0:  fn = FN_SLL;
        1:  fn = FN_SRL;
        2:  fn = FN_SRA;
        3:  fn = FN_SLLV;
        4:  fn = FN_SRLV;
        5:  fn = FN_SRAV;
        6:  fn = FN_ADD;
        7:  fn = FN_ADDU;
        8:  fn = FN_SUB;
        9:  fn = FN_SUBU;
        10: fn = FN_AND;
        11: fn = FN_OR;
        12: fn = FN_XOR;
        13: fn = FN_NOR;
        14: fn = FN_SLT;
        default: fn = FN_SLTU;
      endcase
      w.instruction = {OP_RTYPE, rs, rt, rd, 5'($urandom_range(31)), fn};
    end else if (pick < 80) begin
      case ($urandom_range(7))
        0: op = OP_ADDI;
        1: op = OP_ADDIU;
        2: op = OP_SLTI;
        3: op = OP_SLTIU;
        4: op = OP_ANDI;
        5: op = OP_ORI;
        6: op = OP_XORI;
        default: op = OP_LUI;
      endcase
      w.instruction = {op, rs, rt, 16'($urandom())};
    end else if (pick < 90) begin
      w.kind       = KIND_READ;
      w.read_index = pick_reg();
    end else if (pick < 92) begin
      w.kind = KIND_CLEAR;
    end else if (pick < 94) begin
      w.kind = KIND_NONE;
    end
    return w;
  endfunction

  // called at a falling edge; returns at the falling edge after acceptance
  task automatic send_word(input req_t w, input bit fixed, input rsp_t want);
    rsp_t got;
    if (!calm) begin
      while ($urandom_range(99) < 29) begin
        req_valid <= 1'b0;
        @(negedge clk);
      end
    end
    req_valid <= 1'b1;
    req       <= w;
    @(posedge clk);
    while (req_stall) @(posedge clk);
    got = exec_predict(w);
    pending_rsp.push_back(fixed ? want : got);
    @(negedge clk);
  endtask

  task automatic drain_pending();
    req_valid <= 1'b0;
    @(negedge clk);
    while (pending_rsp.size() != 0) @(negedge clk);
  endtask

  initial begin
    forever begin
      @(negedge clk);
      rsp_stall <= !calm && ($urandom_range(99) < 29);
    end
  end

  always @(posedge clk) begin
    if (!rst && rsp_valid && !rsp_stall) begin
      if (pending_rsp.size() == 0) begin
        $error("result word with no expectation: %p", rsp);
        mismatch_cnt++;
      end else begin
        chk_want = pending_rsp.pop_front();
        if (rsp.dest_index !== chk_want.dest_index) begin
          $error("dest_index: expected %0d, got %0d", chk_want.dest_index, rsp.dest_index);
          mismatch_cnt++;
        end
        if (rsp.value !== chk_want.value) begin
          $error("value: expected %h, got %h", chk_want.value, rsp.value);
          mismatch_cnt++;
        end
        if (rsp.wrote !== chk_want.wrote) begin
          $error("wrote: expected %b, got %b", chk_want.wrote, rsp.wrote);
          mismatch_cnt++;
        end
        if (rsp.unknown !== chk_want.unknown) begin
          $error("unknown: expected %b, got %b", chk_want.unknown, rsp.unknown);
          mismatch_cnt++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("mips_alu_execute_regfile_tb: done, errors");
      $finish;
    end
  end

  initial begin
    foreach (gpr[i]) gpr[i] = '0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    add_row(word(KIND_READ, 32'hFFFFFFFF, 5'd5), 1, res(5'd5, 32'h0, 0, 0));
    add_row(iw(OP_LUI, 5'd31, 5'd0, 16'h8000), 1, res(5'd31, 32'h80000000, 1, 0));
    add_row(iw(OP_ADDIU, 5'd30, 5'd0, 16'hFFFF), 1, res(5'd30, 32'hFFFFFFFF, 1, 0));
    add_row(iw(OP_ORI, 5'd2, 5'd0, 16'hFFFF), 1, res(5'd2, 32'h0000FFFF, 1, 0));
    add_row(iw(OP_ADDI, 5'd3, 5'd31, 16'h8000), 0, '0);
    add_row(rw(FN_ADD, 5'd4, 5'd31, 5'd30, 5'd0), 0, '0);
    add_row(rw(FN_ADDU, 5'd5, 5'd30, 5'd30, 5'd0), 0, '0);
    add_row(rw(FN_SUB, 5'd6, 5'd31, 5'd2, 5'd0), 0, '0);
    add_row(rw(FN_SUBU, 5'd7, 5'd0, 5'd31, 5'd0), 0, '0);
    add_row(rw(FN_SLL, 5'd8, 5'd0, 5'd30, 5'd31), 0, '0);
    add_row(rw(FN_SRL, 5'd9, 5'd0, 5'd31, 5'd31), 0, '0);
    add_row(rw(FN_SRA, 5'd10, 5'd0, 5'd31, 5'd31), 0, '0);
    add_row(rw(FN_SLLV, 5'd11, 5'd2, 5'd30, 5'd0), 0, '0);
    add_row(rw(FN_SRLV, 5'd12, 5'd2, 5'd31, 5'd0), 0, '0);
    add_row(rw(FN_SRAV, 5'd13, 5'd2, 5'd31, 5'd0), 0, '0);
    add_row(rw(FN_AND, 5'd14, 5'd31, 5'd30, 5'd0), 0, '0);
    add_row(rw(FN_OR, 5'd15, 5'd31, 5'd2, 5'd0), 0, '0);
    add_row(rw(FN_XOR, 5'd16, 5'd30, 5'd2, 5'd0), 0, '0);
    add_row(rw(FN_NOR, 5'd17, 5'd31, 5'd2, 5'd0), 0, '0);
    add_row(rw(FN_SLT, 5'd18, 5'd31, 5'd0, 5'd0), 0, '0);
    add_row(rw(FN_SLTU, 5'd19, 5'd31, 5'd0, 5'd0), 0, '0);
    add_row(iw(OP_SLTI, 5'd20, 5'd31, 16'h0001), 0, '0);
    add_row(iw(OP_SLTIU, 5'd21, 5'd0, 16'h8000), 0, '0);
    add_row(iw(OP_ANDI, 5'd22, 5'd30, 16'hFFFF), 0, '0);
    add_row(iw(OP_XORI, 5'd23, 5'd30, 16'hFFFF), 0, '0);
    add_row(iw(OP_ADDIU, 5'd0, 5'd30, 16'h0005), 1, res(5'd0, 32'h0, 0, 0));
    add_row(iw(OP_LW, 5'd24, 5'd30, 16'h0000), 1, res(5'd0, 32'h0, 0, 1));
    add_row(iw(OP_REGIMM, 5'd25, 5'd31, 16'hFFFF), 1, res(5'd0, 32'h0, 0, 1));
    add_row(rw(FN_MULT, 5'd26, 5'd31, 5'd30, 5'd0), 1, res(5'd0, 32'h0, 0, 1));
    add_row(word(KIND_NONE, 32'hFFFFFFFF, 5'd31), 1, res(5'd0, 32'h0, 0, 0));
    add_row(word(KIND_READ, 32'h0, 5'd31), 1, res(5'd31, 32'h80000000, 0, 0));
    add_row(word(KIND_CLEAR, 32'hFFFFFFFF, 5'd31), 1, res(5'd0, 32'h0, 0, 0));
    add_row(word(KIND_READ, 32'h0, 5'd31), 1, res(5'd31, 32'h0, 0, 0));

    foreach (dir_tab[i]) send_word(dir_tab[i].w, dir_tab[i].fixed, dir_tab[i].want);
    drain_pending();

    for (int n = 0; n < 800; n++) begin
      calm <= (n >= 300 && n < 450);
      if (n == 550) drain_pending();
      send_word(rand_word(), 0, '0);
    end

    drain_pending();
    repeat (8) @(negedge clk);
    if (mismatch_cnt == 0 && pending_rsp.size() == 0) begin
      $display("mips_alu_execute_regfile_tb: done, clean");
    end else begin
      $display("mips_alu_execute_regfile_tb: done, errors");
    end
    $finish;
  end

endmodule
